/* hdl/ansf_pkg.sv */
package ansf_pkg;

  localparam int PACKET_LEN_BITS = 20;

  typedef enum logic [2:0] {
    PH_PREFIX   = 3'd0,
    PH_HEADER   = 3'd1,
    PH_BODY     = 3'd2,
    PH_SEI_TYPE = 3'd3,
    PH_SEI_SIZE = 3'd4,
    PH_CAPTION  = 3'd5,
    PH_OTHER    = 3'd6,
    PH_SKIP     = 3'd7
  } phase_t;

  localparam logic [4:0] SEI_UNIT_TYPE = 5'd6;
  localparam logic [15:0] CAPTION_PAYLOAD = 16'd4;
  localparam logic [7:0] EXT_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [19:0] packet_bytes;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic [4:0] unit_type;
    logic       payload_first;
    logic       payload_last;
    logic       size_error;
    logic       packet_end;
  } out_item_t;

  // queue entry: byte plus front-end classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       skip;       // no packet bytes left, byte is skipped outright
    logic       tail4;      // fewer than four bytes remain including this one
    logic [PACKET_LEN_BITS-1:0] rem_after;  // packet bytes left after this one
  } fq_entry_t;

endpackage

/* hdl/ansf_front.sv */
module ansf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ansf_pkg::in_item_t  in_data,
  output logic                q_valid,
  input  logic                q_stall,
  output ansf_pkg::fq_entry_t q_data
);
  import ansf_pkg::*;

  logic                       in_packet_r, in_packet_nxt;
  logic [PACKET_LEN_BITS-1:0] left_r, left_nxt;
  logic [PACKET_LEN_BITS-1:0] rem;
  logic                       acc;

  assign in_stall = q_stall;
  assign acc = in_valid && !in_stall;

  // packet byte counter, latched on the first byte of each packet
  always_comb begin
    rem = in_packet_r ? left_r : PACKET_LEN_BITS'(in_data.packet_bytes);
    left_nxt = (rem == '0) ? rem : rem - 1'b1;
    in_packet_nxt = !in_data.last_byte;
    q_valid = in_valid;
    q_data.data_byte = in_data.data_byte;
    q_data.last_byte = in_data.last_byte;
    q_data.skip = (rem == '0);
    q_data.tail4 = (rem < PACKET_LEN_BITS'(4));
    q_data.rem_after = left_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      left_r <= '0;
    end else if (acc) begin
      in_packet_r <= in_packet_nxt;
      left_r <= left_nxt;
    end
  end
endmodule

/* hdl/ansf_queue.sv */
module ansf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_stall,
  input  ansf_pkg::fq_entry_t wr_data,
  output logic                rd_valid,
  input  logic                rd_stall,
  output ansf_pkg::fq_entry_t rd_data
);
  import ansf_pkg::*;

  // two-entry queue
  fq_entry_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

/* hdl/ansf_back.sv */
module ansf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_stall,
  input  ansf_pkg::fq_entry_t q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ansf_pkg::out_item_t out_data
);
  import ansf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [31:0] ubl_r, ubl_nxt;
  logic [4:0]  ctype_r, ctype_nxt;
  logic [15:0] tsum_r, tsum_nxt;
  logic [31:0] ssum_r, ssum_nxt;
  logic        fpend_r, fpend_nxt;
  logic        inpkt_r, inpkt_nxt;
  logic        ov_r;
  out_item_t   od_r, od_nxt;
  logic        acc;
  phase_t      ph;
  logic [7:0]  b;
  logic [16:0] tadd;
  logic [32:0] sadd;
  logic [31:0] ubl_dec;
  logic        ubl_zero;

  assign q_stall = ov_r && out_stall;
  assign acc = q_valid && !q_stall;
  assign out_valid = ov_r;
  assign out_data = od_r;

  // parsing state update for one byte
  always_comb begin
    b = q_data.data_byte;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    pcnt_nxt = pcnt_r;
    ubl_nxt = ubl_r;
    ctype_nxt = ctype_r;
    tsum_nxt = tsum_r;
    ssum_nxt = ssum_r;
    fpend_nxt = fpend_r;
    ph = phase_r;
    if (!inpkt_r) begin
      ph = PH_PREFIX;
      shift_nxt = '0;
      pcnt_nxt = '0;
      fpend_nxt = 1'b0;
    end
    ubl_dec = (ubl_r == '0) ? ubl_r : ubl_r - 1'b1;
    ubl_zero = (ubl_dec == '0);
    tadd = {1'b0, tsum_r} + {9'd0, b};
    sadd = {1'b0, ssum_r} + {25'd0, b};
    od_nxt.byte_out = b;
    od_nxt.byte_role = PH_SKIP;
    od_nxt.unit_type = '0;
    od_nxt.payload_first = 1'b0;
    od_nxt.payload_last = 1'b0;
    od_nxt.size_error = 1'b0;
    od_nxt.packet_end = q_data.last_byte;
    phase_nxt = ph;
    if (q_data.skip) begin
      phase_nxt = PH_SKIP;
    end else begin
      unique case (ph)
        PH_PREFIX: begin
          if (pcnt_nxt == 2'd0 && q_data.tail4) begin
            phase_nxt = PH_SKIP;
          end else begin
            od_nxt.byte_role = PH_PREFIX;
            shift_nxt = {shift_nxt[23:0], b};
            if (pcnt_nxt == 2'd3) begin
              pcnt_nxt = 2'd0;
              if (shift_nxt == '0 ||
                  shift_nxt > {{(32-PACKET_LEN_BITS){1'b0}}, q_data.rem_after}) begin
                od_nxt.size_error = 1'b1;
                phase_nxt = PH_SKIP;
              end else begin
                ubl_nxt = shift_nxt;
                phase_nxt = PH_HEADER;
              end
            end else begin
              pcnt_nxt = pcnt_nxt + 2'd1;
            end
          end
        end
        PH_HEADER: begin
          od_nxt.byte_role = PH_HEADER;
          ctype_nxt = b[4:0];
          od_nxt.unit_type = b[4:0];
          ubl_nxt = ubl_dec;
          if (ubl_zero) phase_nxt = PH_PREFIX;
          else if (b[4:0] == SEI_UNIT_TYPE) begin
            tsum_nxt = '0;
            phase_nxt = PH_SEI_TYPE;
          end else phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          od_nxt.byte_role = PH_BODY;
          od_nxt.unit_type = ctype_r;
          ubl_nxt = ubl_dec;
          if (ubl_zero) phase_nxt = PH_PREFIX;
        end
        PH_SEI_TYPE: begin
          od_nxt.byte_role = PH_SEI_TYPE;
          od_nxt.unit_type = ctype_r;
          ubl_nxt = ubl_dec;
          tsum_nxt = tadd[16] ? 16'hFFFF : tadd[15:0];
          if (b != EXT_BYTE) begin
            ssum_nxt = '0;
            phase_nxt = PH_SEI_SIZE;
          end
          if (ubl_zero) phase_nxt = PH_PREFIX;
        end
        PH_SEI_SIZE: begin
          od_nxt.byte_role = PH_SEI_SIZE;
          od_nxt.unit_type = ctype_r;
          ubl_nxt = ubl_dec;
          ssum_nxt = sadd[32] ? 32'hFFFF_FFFF : sadd[31:0];
          if (ubl_zero) phase_nxt = PH_PREFIX;
          else if (b != EXT_BYTE) begin
            if (ssum_nxt == '0) begin
              tsum_nxt = '0;
              phase_nxt = PH_SEI_TYPE;
            end else if (tsum_r == CAPTION_PAYLOAD && ssum_nxt <= ubl_dec) begin
              fpend_nxt = 1'b1;
              phase_nxt = PH_CAPTION;
            end else phase_nxt = PH_OTHER;
          end
        end
        PH_CAPTION, PH_OTHER: begin
          od_nxt.byte_role = ph;
          od_nxt.unit_type = ctype_r;
          ubl_nxt = ubl_dec;
          if (ssum_r != '0) ssum_nxt = ssum_r - 1'b1;
          if (ph == PH_CAPTION) begin
            od_nxt.payload_first = fpend_nxt;
            fpend_nxt = 1'b0;
            od_nxt.payload_last = (ssum_nxt == '0);
          end
          if (ubl_zero) phase_nxt = PH_PREFIX;
          else if (ssum_nxt == '0) begin
            tsum_nxt = '0;
            phase_nxt = PH_SEI_TYPE;
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
    end
    inpkt_nxt = !q_data.last_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (acc) od_r <= od_nxt;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      shift_r <= '0;
      pcnt_r <= '0;
      ubl_r <= '0;
      ctype_r <= '0;
      tsum_r <= '0;
      ssum_r <= '0;
      fpend_r <= 1'b0;
      inpkt_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        pcnt_r <= pcnt_nxt;
        ubl_r <= ubl_nxt;
        ctype_r <= ctype_nxt;
        tsum_r <= tsum_nxt;
        ssum_r <= ssum_nxt;
        fpend_r <= fpend_nxt;
        inpkt_r <= inpkt_nxt;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end
endmodule

/* hdl/avcc_nal_sei_framer_unit.sv */
// channel | ports                        | payload
// input   | in_valid, in_stall, in_data   | ansf_pkg::in_item_t
// output  | out_valid, out_stall, out_data| ansf_pkg::out_item_t
//
// one byte per cycle sustained while out_stall stays low; each byte passes through
// the front byte counter, the two-entry queue and the back parser with output register
// reset is synchronous, active low, and leaves the parser awaiting a packet
// an output stall fills the queue, after which in_stall rises
module avcc_nal_sei_framer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ansf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ansf_pkg::out_item_t out_data
);
  import ansf_pkg::*;

  logic      fw_valid, fw_stall, qr_valid, qr_stall;
  fq_entry_t fw_data, qr_data;

  ansf_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid(fw_valid), .q_stall(fw_stall), .q_data(fw_data)
  );

  ansf_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fw_valid), .wr_stall(fw_stall), .wr_data(fw_data),
    .rd_valid(qr_valid), .rd_stall(qr_stall), .rd_data(qr_data)
  );

  ansf_back u_back (
    .clk, .rst_n,
    .q_valid(qr_valid), .q_stall(qr_stall), .q_data(qr_data),
    .out_valid, .out_stall, .out_data
  );
endmodule

/* sim/ansf_checker.sv */
module ansf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ansf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ansf_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ansf_pkg::*;

  // framer state mirror
  phase_t      fr_phase;
  logic [19:0] pkt_left;
  logic [31:0] len_shift;
  logic [1:0]  len_count;
  logic [31:0] nal_left;
  logic [4:0]  nal_type;
  logic [15:0] sei_type_acc;
  logic [31:0] sei_size_acc;
  logic        open_pkt;
  logic        caption_first;

  out_item_t tagged_q[$];

  function automatic logic [15:0] add16_sat(logic [15:0] a, logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [31:0] add32_sat(logic [31:0] a, logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic tag_byte(input in_item_t it);
    out_item_t r;
    logic [19:0] rem;
    logic [7:0]  b;
    b = it.data_byte;
    r = '0;
    r.byte_out = b;
    r.byte_role = PH_SKIP;
    r.packet_end = it.last_byte;
    if (!open_pkt) begin
      pkt_left = it.packet_bytes;
      fr_phase = PH_PREFIX;
      len_count = 2'd0;
      len_shift = '0;
      caption_first = 1'b0;
      open_pkt = 1'b1;
    end
    if (pkt_left == 0) begin
      fr_phase = PH_SKIP;
    end else begin
      rem = pkt_left;
      pkt_left = pkt_left - 20'd1;
      case (fr_phase)
        PH_PREFIX: begin
          if (len_count == 0 && rem < 4) begin
            fr_phase = PH_SKIP;
          end else begin
            r.byte_role = PH_PREFIX;
            len_shift = {len_shift[23:0], b};
            if (len_count == 3) begin
              len_count = 2'd0;
              if (len_shift == 0 || len_shift > 32'(rem - 20'd1)) begin
                r.size_error = 1;
                fr_phase = PH_SKIP;
              end else begin
                nal_left = len_shift;
                fr_phase = PH_HEADER;
              end
            end else begin
              len_count++;
            end
          end
        end
        PH_HEADER: begin
          r.byte_role = PH_HEADER;
          nal_type = b[4:0];
          r.unit_type = nal_type;
          if (nal_left != 0) nal_left--;
          if (nal_left == 0) fr_phase = PH_PREFIX;
          else if (nal_type == SEI_UNIT_TYPE) begin
            sei_type_acc = '0;
            fr_phase = PH_SEI_TYPE;
          end else fr_phase = PH_BODY;
        end
        PH_BODY: begin
          r.byte_role = PH_BODY;
          r.unit_type = nal_type;
          if (nal_left != 0) nal_left--;
          if (nal_left == 0) fr_phase = PH_PREFIX;
        end
        PH_SEI_TYPE: begin
          r.byte_role = PH_SEI_TYPE;
          r.unit_type = nal_type;
          if (nal_left != 0) nal_left--;
          sei_type_acc = add16_sat(sei_type_acc, b);
          if (b != EXT_BYTE) begin
            sei_size_acc = '0;
            fr_phase = PH_SEI_SIZE;
          end
          if (nal_left == 0) fr_phase = PH_PREFIX;
        end
        PH_SEI_SIZE: begin
          r.byte_role = PH_SEI_SIZE;
          r.unit_type = nal_type;
          if (nal_left != 0) nal_left--;
          sei_size_acc = add32_sat(sei_size_acc, b);
          if (b == EXT_BYTE) begin
            if (nal_left == 0) fr_phase = PH_PREFIX;
          end else if (nal_left == 0) fr_phase = PH_PREFIX;
          else if (sei_size_acc == 0) begin
            sei_type_acc = '0;
            fr_phase = PH_SEI_TYPE;
          end else if (sei_type_acc == CAPTION_PAYLOAD && sei_size_acc <= nal_left) begin
            caption_first = 1'b1;
            fr_phase = PH_CAPTION;
          end else fr_phase = PH_OTHER;
        end
        PH_CAPTION, PH_OTHER: begin
          r.byte_role = fr_phase;
          r.unit_type = nal_type;
          if (nal_left != 0) nal_left--;
          if (sei_size_acc != 0) sei_size_acc--;
          if (fr_phase == PH_CAPTION) begin
            r.payload_first = caption_first;
            caption_first = 1'b0;
            r.payload_last = (sei_size_acc == 0);
          end
          if (nal_left == 0) fr_phase = PH_PREFIX;
          else if (sei_size_acc == 0) begin
            sei_type_acc = '0;
            fr_phase = PH_SEI_TYPE;
          end
        end
        default: fr_phase = PH_SKIP;
      endcase
    end
    if (it.last_byte) open_pkt = 1'b0;
    tagged_q.push_back(r);
  endtask

  assign pending = tagged_q.size();

  // watch both channels at each rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      fr_phase = PH_PREFIX;
      pkt_left = '0; len_shift = '0; len_count = '0; nal_left = '0;
      nal_type = '0; sei_type_acc = '0; sei_size_acc = '0;
      open_pkt = 1'b0; caption_first = 1'b0;
      fail_count <= 0;
      tagged_q.delete();
    end else begin
      if (in_valid && !in_stall) tag_byte(in_data);
      if (out_valid && !out_stall) begin
        if (tagged_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected transfer %p", out_data);
        end else begin
          want = tagged_q.pop_front();
          if (want !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch exp %p got %p", want, out_data);
          end
        end
      end
    end
  end
endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ansf_pkg::*;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  int fail_count, pending;
  int send_idle, recv_idle;
  bit hold_recv;
  int cycles;
  int sent;

  avcc_nal_sei_framer_unit dut (.*);
  ansf_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver stall generation
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  byte pkt[$];

  // send one packet, last byte flagged; len is the latched length
  task automatic send_packet(input int len);
    for (int i = 0; i < pkt.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 0;
        @(negedge clk);
      end
      in_valid <= 1;
      in_data.data_byte <= pkt[i];
      in_data.packet_bytes <= (i == 0) ? 20'(len) : 20'($urandom);
      in_data.last_byte <= (i == pkt.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 0;
    sent += pkt.size();
    pkt.delete();
  endtask

  task automatic add_nal(input int n, input byte hdr);
    pkt.push_back(n[31:24]); pkt.push_back(n[23:16]);
    pkt.push_back(n[15:8]); pkt.push_back(n[7:0]);
    if (n > 0) pkt.push_back(hdr);
    for (int i = 1; i < n; i++) pkt.push_back(8'($urandom));
  endtask

  // sei unit with random messages, mostly caption payloads
  task automatic add_sei();
    byte body[$];
    int sz, ty;
    int msgs = $urandom_range(1, 3);
    for (int m = 0; m < msgs; m++) begin
      ty = ($urandom_range(3) != 0) ? 4 : $urandom_range(0, 600);
      sz = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(9) == 0) sz = 300;
      while (ty >= 255) begin body.push_back(8'hFF); ty -= 255; end
      body.push_back(8'(ty));
      while (sz >= 255) begin body.push_back(8'hFF); sz -= 255; end
      body.push_back(8'(sz));
      for (int i = 0; i < sz + ($urandom_range(5) == 0 ? -1 : 0); i++)
        body.push_back(8'($urandom));
    end
    if ($urandom_range(9) == 0) body.push_back(8'h80);
    add_nal(body.size() + 1, 8'(8'h06 | ($urandom_range(7) << 5)));
    for (int i = 0; i < body.size(); i++) pkt[pkt.size() - body.size() + i] = body[i];
  endtask

  task automatic random_packet();
    int len;
    int units = $urandom_range(1, 3);
    for (int u = 0; u < units; u++) begin
      if ($urandom_range(1)) add_sei();
      else add_nal($urandom_range(1, 6), 8'($urandom));
    end
    len = pkt.size();
    case ($urandom_range(9))
      0: len = len + $urandom_range(1, 3);
      1: len = len - $urandom_range(0, 3);
      2: pkt[$urandom_range(0, 3)] = 8'($urandom);
      3: begin pkt.delete(); for (int i = 0; i < $urandom_range(1, 6); i++)
         pkt.push_back(8'($urandom)); len = $urandom; end
      default: ;
    endcase
    if (len < 0) len = 0;
    send_packet(len);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; hold_recv = 0;
    send_idle = 0; recv_idle = 0; sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed: sei caption, zero size, extensions, bad sizes, tails
    pkt = '{0, 0, 0, 10, 8'h06, 4, 3, 8'hAA, 8'h55, 0, 0, 8'hFF, 1, 8'h80};
    send_packet(14);
    pkt = '{0, 0, 0, 0, 8'hFF};
    send_packet(5);
    pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1};
    send_packet(5);
    pkt = '{0, 0, 0, 2, 8'h05, 8'hFF, 1, 2};
    send_packet(8);
    pkt = '{0, 0, 0, 4, 8'h06, 4, 8'hFF, 1};
    send_packet(20'hFFFFF);
    pkt = '{1, 2};
    send_packet(0);
    drain();
    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      send_idle = (phase_i == 0) ? 28 : (phase_i == 1) ? 79 : 0;
      recv_idle = (phase_i == 0) ? 79 : (phase_i == 1) ? 28 : 0;
      while (sent < 130 * (phase_i + 1)) begin
        random_packet();
      end
      if (phase_i == 1) begin
        // long output hold while the sender keeps pushing
        fork
          begin hold_recv = 1; repeat (60) @(posedge clk); hold_recv = 0; end
          random_packet();
        join
        drain();
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule

/* filelist.f */
hdl/ansf_pkg.sv
hdl/ansf_front.sv
hdl/ansf_queue.sv
hdl/ansf_back.sv
hdl/avcc_nal_sei_framer_unit.sv
sim/ansf_checker.sv
sim/tb.sv
